// ----- sv/scka_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and register codes for the soft chroma key alpha block
package scka_pkg;

  // rows the frame may have; default crop row sits past every row
  localparam int MaxRowsDef = 16384;

  // field widths
  localparam int ColorW  = 8;
  localparam int RowW    = 14;
  localparam int KeyW    = 9;
  localparam int CropW   = 15;
  localparam int SumW    = 10;
  localparam int CountW  = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 15;

  // datapath widths
  localparam int AluW   = 31;
  localparam int DistW  = 15;
  localparam int ProdW  = 20;
  localparam int StepW  = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCrop    = 2'd2;

  // configuration reset values
  localparam logic [KeyW-1:0] KeyLowRst  = 9'd50;
  localparam logic [KeyW-1:0] KeyHighRst = 9'd85;

  // corner samples per background estimate
  localparam logic [CountW-1:0] CornerMax = 3'd4;

  // shared unit operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // configuration register set
  typedef struct packed {
    logic [KeyW-1:0]  key_low;
    logic [KeyW-1:0]  key_high;
    logic [CropW-1:0] crop_start_row;
  } cfg_t;

endpackage

// ----- sv/soft_chroma_key_alpha_unit.sv -----
`timescale 1ns / 1ps
// Soft chroma key alpha: corner words build the background, pixel words get an alpha.
// Corner word: no result word; in_ready stays high, as the sequencer stays idle.
// Pixel word: squares, square root and threshold check, plus ramp setup and divide when
// needed (16 square root steps and 8 divide steps on the one shared add/sub unit).
// Words are not overlapped: in_ready is high only while the sequencer is idle.
// Synchronous active-low reset clears background sums and count, restores key registers.
module soft_chroma_key_alpha_unit #(
  parameter int MAX_ROWS = scka_pkg::MaxRowsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scka_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [scka_pkg::CfgDataW-1:0]    cfg_data,
  // input words
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [scka_pkg::ColorW-1:0]      in_red,
  input  logic [scka_pkg::ColorW-1:0]      in_green,
  input  logic [scka_pkg::ColorW-1:0]      in_blue,
  input  logic [scka_pkg::RowW-1:0]        in_row,
  // result words
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [scka_pkg::ColorW-1:0]      out_red,
  output logic [scka_pkg::ColorW-1:0]      out_green,
  output logic [scka_pkg::ColorW-1:0]      out_blue,
  output logic [scka_pkg::ColorW-1:0]      out_alpha
);
  import scka_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQRT,
    S_CHECK,
    S_DEN,
    S_X,
    S_M510,
    S_ADD,
    S_DIV,
    S_DONE
  } state_t;

  cfg_t cfg;

  // control state
  state_t             state_r, state_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SumW-1:0]    sum_red_r, sum_red_nxt;
  logic [SumW-1:0]    sum_green_r, sum_green_nxt;
  logic [SumW-1:0]    sum_blue_r, sum_blue_nxt;
  logic [CountW-1:0]  corner_cnt_r, corner_cnt_nxt;

  // payload
  logic [ColorW-1:0]  pix_red_r, pix_red_nxt;
  logic [ColorW-1:0]  pix_green_r, pix_green_nxt;
  logic [ColorW-1:0]  pix_blue_r, pix_blue_nxt;
  logic [RowW-1:0]    pix_row_r, pix_row_nxt;
  logic [ProdW-1:0]   prod_r, prod_nxt;
  logic [AluW-1:0]    acc_r, acc_nxt;
  logic [AluW-1:0]    root_r, root_nxt;
  logic [DistW-1:0]   den_r, den_nxt;
  logic [ColorW-1:0]  alpha_r, alpha_nxt;
  logic [ColorW-1:0]  o_red_r, o_red_nxt;
  logic [ColorW-1:0]  o_green_r, o_green_nxt;
  logic [ColorW-1:0]  o_blue_r, o_blue_nxt;
  logic [ColorW-1:0]  o_alpha_r, o_alpha_nxt;

  // shared unit
  alu_op_t            alu_op;
  logic [AluW-1:0]    alu_a, alu_b, alu_res;
  logic               alu_ge;

  // helpers
  logic               in_fire;
  logic [ColorW-1:0]  chan_c;
  logic [SumW-1:0]    chan_sum, chan_x4, chan_diff;
  logic [AluW-1:0]    sqrt_bit;
  logic [DistW-1:0]   dist_val, lo_d, hi_d;

  scka_regs #(
    .MAX_ROWS (MAX_ROWS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scka_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_red   = o_red_r;
  assign out_green = o_green_r;
  assign out_blue  = o_blue_r;
  assign out_alpha = o_alpha_r;

  // channel picked by the square step: quarter-unit absolute difference
  always_comb begin
    case (step_r[1:0])
      2'd0:    begin chan_c = pix_red_r;   chan_sum = sum_red_r;   end
      2'd1:    begin chan_c = pix_green_r; chan_sum = sum_green_r; end
      default: begin chan_c = pix_blue_r;  chan_sum = sum_blue_r;  end
    endcase
    chan_x4   = {chan_c, 2'b00};
    chan_diff = (chan_x4 >= chan_sum) ? (chan_x4 - chan_sum) : (chan_sum - chan_x4);
  end

  // distance and ramp ends in 1/64 units
  assign sqrt_bit = AluW'(1) << {step_r, 1'b0};
  assign dist_val = root_r[DistW-1:0];
  assign lo_d     = {cfg.key_low, 6'b000000};
  assign hi_d     = {cfg.key_high, 6'b000000};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r;
    sum_red_nxt    = sum_red_r;
    sum_green_nxt  = sum_green_r;
    sum_blue_nxt   = sum_blue_r;
    corner_cnt_nxt = corner_cnt_r;
    pix_red_nxt    = pix_red_r;
    pix_green_nxt  = pix_green_r;
    pix_blue_nxt   = pix_blue_r;
    pix_row_nxt    = pix_row_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    root_nxt       = root_r;
    den_nxt        = den_r;
    alpha_nxt      = alpha_r;
    o_red_nxt      = o_red_r;
    o_green_nxt    = o_green_r;
    o_blue_nxt     = o_blue_r;
    o_alpha_nxt    = o_alpha_r;
    alu_op         = ALU_ADD;
    alu_a          = acc_r;
    alu_b          = {{(AluW-ProdW){1'b0}}, prod_r};

    // result register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_mode) begin
            // corner sample: add to sum, or restart after a full set
            if (corner_cnt_r >= CornerMax) begin
              sum_red_nxt    = {2'b00, in_red};
              sum_green_nxt  = {2'b00, in_green};
              sum_blue_nxt   = {2'b00, in_blue};
              corner_cnt_nxt = 3'd1;
            end else begin
              sum_red_nxt    = sum_red_r + {2'b00, in_red};
              sum_green_nxt  = sum_green_r + {2'b00, in_green};
              sum_blue_nxt   = sum_blue_r + {2'b00, in_blue};
              corner_cnt_nxt = corner_cnt_r + 3'd1;
            end
          end else begin
            pix_red_nxt   = in_red;
            pix_green_nxt = in_green;
            pix_blue_nxt  = in_blue;
            pix_row_nxt   = in_row;
            acc_nxt       = '0;
            step_nxt      = '0;
            state_nxt     = S_SQ;
          end
        end
      end

      S_SQ: begin
        // square one channel, accumulate the previous one
        prod_nxt = ProdW'(chan_diff * chan_diff);
        if (step_r != '0) begin
          acc_nxt = alu_res;
        end
        if (step_r == StepW'(3)) begin
          acc_nxt   = {alu_res[AluW-9:0], 8'h00};
          root_nxt  = '0;
          step_nxt  = StepW'(15);
          state_nxt = S_SQRT;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end

      S_SQRT: begin
        // one digit of the square root; partial root never overlaps the trial bit
        alu_op = ALU_SUB;
        alu_b  = root_r | sqrt_bit;
        if (alu_ge) begin
          acc_nxt  = alu_res;
          root_nxt = (root_r >> 1) | sqrt_bit;
        end else begin
          root_nxt = root_r >> 1;
        end
        if (step_r == '0) begin
          state_nxt = S_CHECK;
        end else begin
          step_nxt = step_r - StepW'(1);
        end
      end

      S_CHECK: begin
        // hard threshold and the two flat ends of the ramp
        if (cfg.key_high <= cfg.key_low) begin
          alpha_nxt = (dist_val > lo_d) ? 8'hFF : 8'h00;
          state_nxt = S_DONE;
        end else if (dist_val <= lo_d) begin
          alpha_nxt = 8'h00;
          state_nxt = S_DONE;
        end else if (dist_val >= hi_d) begin
          alpha_nxt = 8'hFF;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DEN;
        end
      end

      S_DEN: begin
        // ramp width
        alu_op    = ALU_SUB;
        alu_a     = {{(AluW-DistW){1'b0}}, hi_d};
        alu_b     = {{(AluW-DistW){1'b0}}, lo_d};
        den_nxt   = alu_res[DistW-1:0];
        state_nxt = S_X;
      end

      S_X: begin
        // offset into the ramp
        alu_op    = ALU_SUB;
        alu_a     = {{(AluW-DistW){1'b0}}, dist_val};
        alu_b     = {{(AluW-DistW){1'b0}}, lo_d};
        acc_nxt   = alu_res;
        state_nxt = S_M510;
      end

      S_M510: begin
        // times 510 as x*512 - x*2
        alu_op    = ALU_SUB;
        alu_a     = {acc_r[AluW-10:0], 9'd0};
        alu_b     = {acc_r[AluW-2:0], 1'b0};
        acc_nxt   = alu_res;
        state_nxt = S_ADD;
      end

      S_ADD: begin
        // half-up rounding term
        alu_op    = ALU_ADD;
        alu_b     = {{(AluW-DistW){1'b0}}, den_r};
        acc_nxt   = alu_res;
        alpha_nxt = '0;
        step_nxt  = StepW'(7);
        state_nxt = S_DIV;
      end

      S_DIV: begin
        // restoring divide by twice the width, one quotient bit per cycle
        alu_op = ALU_SUB;
        alu_b  = {{(AluW-DistW-1){1'b0}}, den_r, 1'b0} << step_r[2:0];
        if (alu_ge) begin
          acc_nxt = alu_res;
        end
        alpha_nxt[step_r[2:0]] = alu_ge;
        if (step_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r - StepW'(1);
        end
      end

      S_DONE: begin
        // hand the word over once the result register is free
        if (!out_valid_r || out_ready) begin
          o_red_nxt     = pix_red_r;
          o_green_nxt   = pix_green_r;
          o_blue_nxt    = pix_blue_r;
          o_alpha_nxt   = ({1'b0, pix_row_r} >= cfg.crop_start_row) ? 8'h00 : alpha_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      sum_red_r    <= '0;
      sum_green_r  <= '0;
      sum_blue_r   <= '0;
      corner_cnt_r <= '0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
      sum_red_r    <= sum_red_nxt;
      sum_green_r  <= sum_green_nxt;
      sum_blue_r   <= sum_blue_nxt;
      corner_cnt_r <= corner_cnt_nxt;
    end
    pix_red_r   <= pix_red_nxt;
    pix_green_r <= pix_green_nxt;
    pix_blue_r  <= pix_blue_nxt;
    pix_row_r   <= pix_row_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    root_r      <= root_nxt;
    den_r       <= den_nxt;
    alpha_r     <= alpha_nxt;
    o_red_r     <= o_red_nxt;
    o_green_r   <= o_green_nxt;
    o_blue_r    <= o_blue_nxt;
    o_alpha_r   <= o_alpha_nxt;
  end

endmodule

// ----- sv/scka_alu.sv -----
`timescale 1ns / 1ps
// shared add / subtract unit with unsigned compare flag
module scka_alu (
  input  scka_pkg::alu_op_t              op,
  input  logic [scka_pkg::AluW-1:0]      a,
  input  logic [scka_pkg::AluW-1:0]      b,
  output logic [scka_pkg::AluW-1:0]      res,
  output logic                           ge
);
  import scka_pkg::*;

  logic [AluW:0]   sum;
  logic [AluW-1:0] b_inv;

  // a + b, or a + ~b + 1 for subtract; carry out means a >= b
  always_comb begin
    b_inv = (op == ALU_SUB) ? ~b : b;
    sum   = {1'b0, a} + {1'b0, b_inv} + {{AluW{1'b0}}, (op == ALU_SUB)};
    res   = sum[AluW-1:0];
    ge    = sum[AluW];
  end

endmodule

// ----- sv/scka_regs.sv -----
`timescale 1ns / 1ps
// configuration registers: key thresholds and crop row
module scka_regs #(
  parameter int MAX_ROWS = scka_pkg::MaxRowsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scka_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [scka_pkg::CfgDataW-1:0]    cfg_data,
  output scka_pkg::cfg_t                   cfg
);
  import scka_pkg::*;

  localparam logic [CropW-1:0] CropRst = CropW'(MAX_ROWS);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg         = cfg_r;

  // register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        RegKeyLow:  cfg_nxt.key_low        = cfg_data[KeyW-1:0];
        RegKeyHigh: cfg_nxt.key_high       = cfg_data[KeyW-1:0];
        RegCrop:    cfg_nxt.crop_start_row = cfg_data[CropW-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_low        <= KeyLowRst;
      cfg_r.key_high       <= KeyHighRst;
      cfg_r.crop_start_row <= CropRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
